@@ design/barycentric_weight_unit_macros.svh @@
// Assertion macros shared by the barycentric weight unit
`ifndef BARYCENTRIC_WEIGHT_UNIT_MACROS_SVH
`define BARYCENTRIC_WEIGHT_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define BWU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BWU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bwu_pkg.sv @@
// Types, constants and helpers of the barycentric weight unit
`timescale 1ns / 1ps
`default_nettype none

package bwu_pkg;

  localparam int COORD_W     = 12;
  localparam int COORD_MAX   = 16;
  localparam int WEIGHT_BITS = 24;

  typedef struct packed {
    logic signed [COORD_W-1:0] vert_a_x;
    logic signed [COORD_W-1:0] vert_a_y;
    logic signed [COORD_W-1:0] vert_b_x;
    logic signed [COORD_W-1:0] vert_b_y;
    logic signed [COORD_W-1:0] vert_c_x;
    logic signed [COORD_W-1:0] vert_c_y;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } bwu_in_t;

  typedef struct packed {
    logic signed [WEIGHT_BITS-1:0] weight_alpha;
    logic signed [WEIGHT_BITS-1:0] weight_beta;
    logic signed [WEIGHT_BITS-1:0] weight_gamma;
    logic                          degenerate;
  } bwu_out_t;

  function automatic logic [COORD_MAX-1:0] coord_ext(logic [COORD_W-1:0] f);
    return {{(COORD_MAX-COORD_W){f[COORD_W-1]}}, f};
  endfunction

endpackage

`default_nettype wire

@@ design/bwu_area.sv @@
// Four-stage edge-function pipeline: differences, products, cross products, magnitudes
`timescale 1ns / 1ps
`default_nettype none

module bwu_area
  import bwu_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_vld,
  input  wire logic signed [COORD_BITS-1:0] ax,
  input  wire logic signed [COORD_BITS-1:0] ay,
  input  wire logic signed [COORD_BITS-1:0] bx,
  input  wire logic signed [COORD_BITS-1:0] by,
  input  wire logic signed [COORD_BITS-1:0] cx,
  input  wire logic signed [COORD_BITS-1:0] cy,
  input  wire logic signed [COORD_BITS-1:0] px,
  input  wire logic signed [COORD_BITS-1:0] py,
  output logic                              out_vld,
  output logic [2*COORD_BITS:0]             mag_area,
  output logic [2*COORD_BITS:0]             mag_na,
  output logic [2*COORD_BITS:0]             mag_nb,
  output logic                              neg_na,
  output logic                              neg_nb,
  output logic                              degen
);

  localparam int D  = COORD_BITS + 1;
  localparam int CW = 2*COORD_BITS + 2;
  localparam int MW = 2*COORD_BITS + 1;

  logic [3:0] vld_r;

  logic signed [D-1:0]  cax_r, cay_r, bax_r, bay_r, cpx_r, cpy_r, bpx_r, bpy_r, pax_r, pay_r;
  logic signed [CW-1:0] pa0_r, pa1_r, pn0_r, pn1_r, pb0_r, pb1_r;
  logic signed [CW-1:0] cr_a_r, cr_n_r, cr_b_r;
  logic [MW-1:0]        mag_a_r, mag_n_r, mag_b_r;
  logic                 neg_n_r, neg_b_r, deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    cax_r <= D'(cx) - D'(ax);
    cay_r <= D'(cy) - D'(ay);
    bax_r <= D'(bx) - D'(ax);
    bay_r <= D'(by) - D'(ay);
    cpx_r <= D'(cx) - D'(px);
    cpy_r <= D'(cy) - D'(py);
    bpx_r <= D'(bx) - D'(px);
    bpy_r <= D'(by) - D'(py);
    pax_r <= D'(px) - D'(ax);
    pay_r <= D'(py) - D'(ay);

    pa0_r <= CW'(cax_r) * CW'(bay_r);
    pa1_r <= CW'(cay_r) * CW'(bax_r);
    pn0_r <= CW'(cpx_r) * CW'(bpy_r);
    pn1_r <= CW'(cpy_r) * CW'(bpx_r);
    pb0_r <= CW'(cax_r) * CW'(pay_r);
    pb1_r <= CW'(cay_r) * CW'(pax_r);

    cr_a_r <= pa0_r - pa1_r;
    cr_n_r <= pn0_r - pn1_r;
    cr_b_r <= pb0_r - pb1_r;

    mag_a_r <= cr_a_r[CW-1] ? MW'(-cr_a_r) : MW'(cr_a_r);
    mag_n_r <= cr_n_r[CW-1] ? MW'(-cr_n_r) : MW'(cr_n_r);
    mag_b_r <= cr_b_r[CW-1] ? MW'(-cr_b_r) : MW'(cr_b_r);
    neg_n_r <= cr_n_r[CW-1] ^ cr_a_r[CW-1];
    neg_b_r <= cr_b_r[CW-1] ^ cr_a_r[CW-1];
    deg_r   <= (cr_a_r == '0);
  end

  assign out_vld  = vld_r[3];
  assign mag_area = mag_a_r;
  assign mag_na   = mag_n_r;
  assign mag_nb   = mag_b_r;
  assign neg_na   = neg_n_r;
  assign neg_nb   = neg_b_r;
  assign degen    = deg_r;

endmodule

`default_nettype wire

@@ design/bwu_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow detect
`timescale 1ns / 1ps
`default_nettype none

module bwu_div
  import bwu_pkg::*;
#(
  parameter int MW        = 25,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_vld,
  input  wire logic [MW-1:0]          num,
  input  wire logic [MW-1:0]          den,
  input  wire logic                   neg,
  output logic                        out_vld,
  output logic [WEIGHT_BITS-1:0]      quo,
  output logic                        ovf,
  output logic                        neg_o
);

  localparam int WB = WEIGHT_BITS;
  localparam int NW = MW + FRAC_BITS;

  logic                vld_r [0:WB];
  logic [MW-1:0]       num_r [0:WB];
  logic [MW-1:0]       den_r [0:WB];
  logic [MW-1:0]       rem_r [0:WB];
  logic [WB-1:0]       q_r   [0:WB];
  logic                ovf_r [0:WB];
  logic                neg_r [0:WB];

  logic [NW-1:0] top_nxt;

  assign top_nxt = {num, {FRAC_BITS{1'b0}}} >> WB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    num_r[0] <= num;
    den_r[0] <= den;
    rem_r[0] <= MW'(top_nxt);
    q_r[0]   <= '0;
    ovf_r[0] <= (top_nxt >= NW'(den));
    neg_r[0] <= neg;
  end

  for (genvar k = 1; k <= WB; k++) begin : g_stage
    localparam int I = WB - k;
    logic          nbit;
    logic [MW:0]   trial;
    logic          ge;

    if (I >= FRAC_BITS) begin : g_bit
      assign nbit = num_r[k-1][I-FRAC_BITS];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign trial = {rem_r[k-1], nbit};
    assign ge    = (trial >= {1'b0, den_r[k-1]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      num_r[k] <= num_r[k-1];
      den_r[k] <= den_r[k-1];
      rem_r[k] <= ge ? MW'(trial - {1'b0, den_r[k-1]}) : MW'(trial);
      q_r[k]   <= q_r[k-1] | (WB'(ge) << I);
      ovf_r[k] <= ovf_r[k-1];
      neg_r[k] <= neg_r[k-1];
    end
  end

  assign out_vld = vld_r[WB];
  assign quo     = q_r[WB];
  assign ovf     = ovf_r[WB];
  assign neg_o   = neg_r[WB];

endmodule

`default_nettype wire

@@ design/barycentric_weight_unit.sv @@
// Top level of the barycentric weight unit
//
// Usage: present the triangle A, B, C and point P on in_word and raise start
// for one cycle. busy is always low, so a word is taken on every cycle that
// start is high; one word per clock is sustained.
// Each word gives one result: out_valid is high for exactly one cycle with
// out_word holding alpha, beta, gamma (signed Q8.16, saturated) and the
// degenerate flag. A zero triangle area sets degenerate and zero weights.
// A word passes, in order, the edge-function stages, a divider setup stage,
// the quotient-bit stages of the two parallel dividers, one per weight bit,
// and the output stages.
// Results leave in accept order. The receiver cannot hold results off and
// none is needed: the pipeline never stalls.
// Reset (rst_n low, synchronous) clears all valid bits; words in flight are
// dropped and no result comes out until new words are accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "barycentric_weight_unit_macros.svh"

module barycentric_weight_unit
  import bwu_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire bwu_in_t  in_word,
  output logic          out_valid,
  output bwu_out_t      out_word
);

  localparam int WB = WEIGHT_BITS;
  localparam int MW = 2*COORD_BITS + 1;
  localparam int GW = WB + 2;

  localparam logic signed [WB-1:0] W_MAX = {1'b0, {(WB-1){1'b1}}};
  localparam logic signed [WB-1:0] W_MIN = {1'b1, {(WB-1){1'b0}}};

  logic                         in_vld;
  logic [COORD_MAX-1:0]         ext [0:7];
  logic                         ar_vld;
  logic [MW-1:0]                mag_area, mag_na, mag_nb;
  logic                         neg_na, neg_nb, ar_deg;
  logic                         da_vld, db_vld;
  logic [WB-1:0]                qa, qb;
  logic                         ovf_a, ovf_b, neg_a, neg_b;
  logic                         deg_line_r [0:WB];
  logic                         f1_vld_r, f1_deg_r;
  logic signed [WB-1:0]         alpha_r, beta_r;
  logic signed [GW-1:0]         gamma_full;
  logic signed [WB-1:0]         gamma_sat;
  logic                         out_valid_r;
  bwu_out_t                     out_word_r;

  function automatic logic signed [WB-1:0] to_weight(logic [WB-1:0] q, logic o, logic n);
    if (o) begin
      return n ? W_MIN : W_MAX;
    end else if (n) begin
      return (q[WB-1] && (|q[WB-2:0])) ? W_MIN : -$signed(q);
    end else begin
      return q[WB-1] ? W_MAX : $signed(q);
    end
  endfunction

  assign busy   = 1'b0;
  assign in_vld = start & ~busy;

  assign ext[0] = coord_ext(in_word.vert_a_x);
  assign ext[1] = coord_ext(in_word.vert_a_y);
  assign ext[2] = coord_ext(in_word.vert_b_x);
  assign ext[3] = coord_ext(in_word.vert_b_y);
  assign ext[4] = coord_ext(in_word.vert_c_x);
  assign ext[5] = coord_ext(in_word.vert_c_y);
  assign ext[6] = coord_ext(in_word.point_x);
  assign ext[7] = coord_ext(in_word.point_y);

  bwu_area #(.COORD_BITS(COORD_BITS)) u_area (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .ax       ($signed(ext[0][COORD_BITS-1:0])),
    .ay       ($signed(ext[1][COORD_BITS-1:0])),
    .bx       ($signed(ext[2][COORD_BITS-1:0])),
    .by       ($signed(ext[3][COORD_BITS-1:0])),
    .cx       ($signed(ext[4][COORD_BITS-1:0])),
    .cy       ($signed(ext[5][COORD_BITS-1:0])),
    .px       ($signed(ext[6][COORD_BITS-1:0])),
    .py       ($signed(ext[7][COORD_BITS-1:0])),
    .out_vld  (ar_vld),
    .mag_area (mag_area),
    .mag_na   (mag_na),
    .mag_nb   (mag_nb),
    .neg_na   (neg_na),
    .neg_nb   (neg_nb),
    .degen    (ar_deg)
  );

  bwu_div #(.MW(MW), .FRAC_BITS(FRAC_BITS)) u_div_alpha (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (ar_vld),
    .num     (mag_na),
    .den     (mag_area),
    .neg     (neg_na),
    .out_vld (da_vld),
    .quo     (qa),
    .ovf     (ovf_a),
    .neg_o   (neg_a)
  );

  bwu_div #(.MW(MW), .FRAC_BITS(FRAC_BITS)) u_div_beta (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (ar_vld),
    .num     (mag_nb),
    .den     (mag_area),
    .neg     (neg_nb),
    .out_vld (db_vld),
    .quo     (qb),
    .ovf     (ovf_b),
    .neg_o   (neg_b)
  );

  always_ff @(posedge clk) begin
    deg_line_r[0] <= ar_deg;
  end

  for (genvar k = 1; k <= WB; k++) begin : g_deg
    always_ff @(posedge clk) begin
      deg_line_r[k] <= deg_line_r[k-1];
    end
  end

  assign gamma_full = (GW'(1) <<< FRAC_BITS) - GW'(alpha_r) - GW'(beta_r);
  assign gamma_sat  = (gamma_full > GW'(W_MAX)) ? W_MAX :
                      (gamma_full < GW'(W_MIN)) ? W_MIN : WB'(gamma_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      f1_vld_r    <= da_vld;
      out_valid_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    alpha_r  <= to_weight(qa, ovf_a, neg_a);
    beta_r   <= to_weight(qb, ovf_b, neg_b);
    f1_deg_r <= deg_line_r[WB];
    out_word_r.degenerate   <= f1_deg_r;
    out_word_r.weight_alpha <= f1_deg_r ? '0 : alpha_r;
    out_word_r.weight_beta  <= f1_deg_r ? '0 : beta_r;
    out_word_r.weight_gamma <= f1_deg_r ? '0 : gamma_sat;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `BWU_ASSERT_IMP(a_div_lockstep, 1'b1, da_vld == db_vld, "divider valid bits disagree")
  `BWU_ASSERT_IMP(a_deg_zero, out_valid && out_word.degenerate,
    out_word.weight_alpha == '0 && out_word.weight_beta == '0 && out_word.weight_gamma == '0,
    "degenerate result with nonzero weight")
  `BWU_ASSERT_NXT(a_out_follows, f1_vld_r, out_valid, "staged word lost at output")

endmodule

`default_nettype wire
